@@ rtl/gcs_pkg.sv @@
// shared types and constants for the grouped column statistics unit
`timescale 1ns / 1ps
package gcs_pkg;
  localparam int unsigned COUNT_W = 24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int unsigned RES_W = 40;

  typedef enum logic [3:0] {
    OP_MIN = 4'd0, OP_MAX = 4'd1, OP_CENTRE = 4'd2, OP_MEAN = 4'd3,
    OP_SUM = 4'd4, OP_SIZE = 4'd5, OP_RADIUS = 4'd6, OP_DIAM = 4'd7,
    OP_VAR = 4'd8, OP_STDDEV = 4'd9
  } op_code_t;

  typedef enum logic [1:0] {
    CFG_OP_COUNT = 2'd0, CFG_OP_LIST = 2'd1, CFG_BLK_FLUSH = 2'd2, CFG_HAS_ID = 2'd3
  } cfg_reg_t;

  // per column accumulator
  typedef struct packed {
    logic signed [15:0] mn;
    logic signed [15:0] mx;
    logic [39:0]        sum;
    logic signed [15:0] mean;
    logic signed [31:0] msq;
  } col_acc_t;

  // lane control from the sequencer
  typedef struct packed {
    logic        start;
    logic        fresh;
    logic [COUNT_W-1:0] cnt;
  } lane_ctl_t;
endpackage

@@ rtl/gcs_lane.sv @@
// one column lane: min/max/sum update and two serial truncating divisions
`timescale 1ns / 1ps
module gcs_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gcs_pkg::lane_ctl_t        ctl,
  input  logic signed [15:0]        x,
  input  gcs_pkg::col_acc_t         acc_in,
  output gcs_pkg::col_acc_t         acc_out,
  output logic                      done
);
  import gcs_pkg::*;

  // dividend magnitudes fit 33 bits, quotient likewise
  localparam int DW = 34;

  logic [5:0]          step_r, step_nxt;
  logic                busy_r, done_r;
  logic [DW-1:0]       q1_r, q2_r;
  logic [COUNT_W:0]    r1_r, r2_r;
  logic                n1_r, n2_r;
  logic [COUNT_W-1:0]  d_r;
  col_acc_t            acc_r;
  logic signed [31:0]  xw;
  logic signed [31:0]  sq;
  logic signed [DW-1:0] dif1, dif2;
  logic [COUNT_W:0]    t1, t2;
  logic [DW-1:0]       q1s, q2s;
  logic signed [DW-1:0] res1, res2;

  assign xw   = 32'(x);
  assign sq   = xw * xw;
  assign dif1 = DW'(x) - DW'(acc_in.mean);
  assign dif2 = DW'(sq) - DW'(acc_in.msq);

  // restoring division, one quotient bit of each per cycle
  assign t1 = {r1_r[COUNT_W-1:0], q1_r[DW-1]};
  assign t2 = {r2_r[COUNT_W-1:0], q2_r[DW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
      done_r <= busy_r && step_r == 6'(DW - 1);
      if (ctl.start && !ctl.fresh) busy_r <= 1'b1;
      else if (busy_r && step_r == 6'(DW - 1)) busy_r <= 1'b0;
    end
  end

  always_comb begin
    step_nxt = step_r;
    if (ctl.start) step_nxt = '0;
    else if (busy_r) step_nxt = step_r + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      r1_r <= '0;
      r2_r <= '0;
      d_r  <= ctl.cnt;
      if (ctl.fresh) begin
        n1_r <= 1'b0;
        n2_r <= 1'b0;
        q1_r <= '0;
        q2_r <= '0;
        acc_r.mn   <= x;
        acc_r.mx   <= x;
        acc_r.sum  <= 40'(x);
        acc_r.mean <= x;
        acc_r.msq  <= sq;
      end else begin
        n1_r <= dif1[DW-1];
        n2_r <= dif2[DW-1];
        q1_r <= dif1[DW-1] ? DW'(-dif1) : DW'(dif1);
        q2_r <= dif2[DW-1] ? DW'(-dif2) : DW'(dif2);
        acc_r.mn   <= (x < acc_in.mn) ? x : acc_in.mn;
        acc_r.mx   <= (x > acc_in.mx) ? x : acc_in.mx;
        acc_r.sum  <= acc_in.sum + 40'(x);
        acc_r.mean <= acc_in.mean;
        acc_r.msq  <= acc_in.msq;
      end
    end else if (busy_r) begin
      if (t1 >= {1'b0, d_r}) begin
        r1_r <= t1 - {1'b0, d_r};
        q1_r <= {q1_r[DW-2:0], 1'b1};
      end else begin
        r1_r <= t1;
        q1_r <= {q1_r[DW-2:0], 1'b0};
      end
      if (t2 >= {1'b0, d_r}) begin
        r2_r <= t2 - {1'b0, d_r};
        q2_r <= {q2_r[DW-2:0], 1'b1};
      end else begin
        r2_r <= t2;
        q2_r <= {q2_r[DW-2:0], 1'b0};
      end
    end
  end

  assign q1s  = q1_r;
  assign q2s  = q2_r;
  assign res1 = n1_r ? -$signed(q1s) : $signed(q1s);
  assign res2 = n2_r ? -$signed(q2s) : $signed(q2s);

  // apply quotients once division completes
  always_comb begin
    acc_out = acc_r;
    acc_out.mean = 16'(DW'(acc_r.mean) + res1);
    acc_out.msq  = 32'(DW'(acc_r.msq) + res2);
  end

  // high in the cycle after the last quotient bit
  assign done = done_r;
endmodule

@@ rtl/gcs_merge.sv @@
// result stage: evaluates one op for one column lane, serial sqrt for stddev
`timescale 1ns / 1ps
module gcs_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [3:0]           code,
  input  gcs_pkg::col_acc_t    acc,
  input  logic [gcs_pkg::COUNT_W-1:0] cnt,
  output logic signed [39:0]   res,
  output logic                 done
);
  import gcs_pkg::*;

  logic signed [47:0] var_c;
  logic signed [31:0] mean_w;
  logic signed [39:0] res_r;
  logic [4:0]         it_r;
  logic               busy_r, done_r;
  logic [33:0]        x_r, r_r, bit_r;
  logic signed [17:0] span;
  logic signed [39:0] comb;

  assign mean_w = 32'(acc.mean);
  assign var_c  = 48'(acc.msq) - 48'(mean_w * mean_w);
  assign span   = 18'(acc.mx) - 18'(acc.mn);

  always_comb begin
    unique case (code)
      OP_MIN:    comb = 40'(acc.mn);
      OP_MAX:    comb = 40'(acc.mx);
      OP_CENTRE: comb = 40'(acc.mn) + 40'(span >>> 1);
      OP_MEAN:   comb = 40'(acc.mean);
      OP_SUM:    comb = $signed(acc.sum);
      OP_SIZE:   comb = 40'(cnt);
      OP_RADIUS: comb = 40'(span >>> 1);
      OP_DIAM:   comb = 40'(span);
      OP_VAR:    comb = 40'(var_c);
      default:   comb = '0;
    endcase
  end

  // done stays high from result ready until a start that begins a square root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        if (code == OP_STDDEV && var_c > 0) begin
          busy_r <= 1'b1;
          done_r <= 1'b0;
        end else done_r <= 1'b1;
      end else if (busy_r && it_r == 5'd16) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // digit-by-digit square root, 17 steps
  always_ff @(posedge clk) begin
    if (start) begin
      res_r <= (code == OP_STDDEV) ? '0 : comb;
      x_r   <= 34'(var_c);
      r_r   <= '0;
      bit_r <= 34'h1_0000_0000;
      it_r  <= '0;
    end else if (busy_r) begin
      it_r <= it_r + 5'd1;
      bit_r <= bit_r >> 2;
      if (x_r >= r_r + bit_r) begin
        x_r <= x_r - (r_r + bit_r);
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      if (it_r == 5'd16) res_r <= 40'((x_r >= r_r + bit_r) ? (r_r >> 1) + bit_r : r_r >> 1);
    end
  end

  assign res  = res_r;
  assign done = done_r;
endmodule

@@ rtl/grouped_column_statistics_unit.sv @@
// grouped column statistics unit: slot table, column lanes and flush sequencer
//
// Input beats on in_ carry cmd (tuser) and block, id and four signed 16-bit
// samples (tdata). A sample beat looks up its id in a table of ID_SLOTS slots,
// then every column lane updates min, max, sum and the two running means with
// serial dividers; for a sample of a known id, in_tready stays low until the
// 34-step division in the lanes completes; a new id or a dropped sample skips
// the division. A block change (block flush enabled) or a cmd 1 beat first
// flushes the table: per valid slot in insertion order and per configured op,
// one out_ beat with the op result for every column, tlast on the final one.
// Each result is computed in S_FOP, stddev of a positive variance by a 17-step
// square root, and is offered in S_FOUT until out_tready takes it; each slot
// is chosen in S_FSEL and closed in S_WAIT.
// A beat waiting on out_ holds its payload while out_tready is low; the block
// takes no new input until the flush is fully delivered.
// Reset clears slot valid bits, block tracking, drop flag and configuration.
// cfg_ready is always high; cfg_ writes (index, data) belong in idle periods.
`timescale 1ns / 1ps
module grouped_column_statistics_unit #(
  parameter int ID_SLOTS = 8,
  parameter int COLUMNS  = 4,
  parameter int MAX_OPS  = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // block_number[31:0], group_id[63:32], value_0..value_3 [127:64]
  input  logic [127:0] in_tdata,
  // cmd
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_id[31:0], out_block[63:32], out_op[67:64], result_0..3 [227:68], pad
  output logic [231:0] out_tdata,
  // dropped_flag
  output logic         out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import gcs_pkg::*;

  localparam int SW = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
  localparam int OW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_LOOK = 7'b0000010, S_UPD = 7'b0000100,
    S_FSEL = 7'b0001000, S_FOP = 7'b0010000, S_FOUT = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]  op_count_r;
  logic [31:0] op_list_r;
  logic        blk_flush_r, has_id_r;
  logic [ID_SLOTS-1:0] valid_r;
  logic [31:0] key_r [ID_SLOTS];
  logic [COUNT_W-1:0] cnt_r [ID_SLOTS];
  col_acc_t    acc_r [ID_SLOTS][COLUMNS];
  logic [31:0] prev_block_r;
  logic        block_seen_r, drop_r;

  logic        cmd_r;
  logic [31:0] blk_r, key_in_r;
  logic [15:0] val_r [4];
  logic [SW-1:0] slot_r;
  logic        fresh_r, pend_r;
  logic [OW-1:0] op_r;
  logic [3:0]  nops;
  logic [COLUMNS-1:0] lane_done, mrg_done;
  col_acc_t    lane_out [COLUMNS];
  logic signed [39:0] mrg_res [COLUMNS];
  lane_ctl_t   lctl;
  logic        mstart, mgo_r, mrg_ok;
  logic [3:0]  code;
  logic        hit, freeok;
  logic [SW-1:0] hit_s, free_s, nxt_s;
  logic        more_slot;
  logic        out_v_r, out_last_r, out_drop_r;
  logic [231:0] out_d_r, out_d_nxt;
  logic [31:0] fblk;

  assign in_tready = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign nops = (op_count_r == 4'd0) ? 4'd1 :
                (op_count_r > 4'(MAX_OPS)) ? 4'(MAX_OPS) : op_count_r;
  assign code = op_list_r[4*op_r +: 4];
  assign fblk = (blk_flush_r && block_seen_r) ? prev_block_r : 32'd0;

  // slot search
  always_comb begin
    hit = 1'b0; hit_s = '0; freeok = 1'b0; free_s = '0;
    more_slot = 1'b0; nxt_s = '0;
    for (int s = ID_SLOTS - 1; s >= 0; s--) begin
      if (valid_r[s] && key_r[s] == key_in_r) begin hit = 1'b1; hit_s = SW'(s); end
      if (!valid_r[s]) begin freeok = 1'b1; free_s = SW'(s); end
      if (valid_r[s]) begin more_slot = 1'b1; nxt_s = SW'(s); end
    end
  end

  assign lctl = '{
    start: state_r == S_LOOK && (hit || freeok) && !pend_r,
    fresh: !hit,
    cnt:   hit ? ((cnt_r[hit_s] < COUNT_MAX) ? cnt_r[hit_s] + COUNT_W'(1) : COUNT_MAX)
               : COUNT_W'(1)
  };
  assign mstart = state_r == S_FSEL && more_slot;
  // merge results are ready once the start cycle has passed
  assign mrg_ok = state_r == S_FOP && !mgo_r && (&mrg_done);

  for (genvar c = 0; c < COLUMNS; c++) begin : g_lane
    gcs_lane u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(lctl), .x(val_r[c]),
      .acc_in(acc_r[hit_s][c]), .acc_out(lane_out[c]), .done(lane_done[c])
    );
    gcs_merge u_merge (
      .clk(clk), .rst_n(rst_n), .start(mgo_r),
      .code(code), .acc(acc_r[slot_r][c]), .cnt(cnt_r[slot_r]),
      .res(mrg_res[c]), .done(mrg_done[c])
    );
  end

  // config and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_count_r <= 4'd1; op_list_r <= '0; blk_flush_r <= 1'b0; has_id_r <= 1'b0;
      valid_r <= '0; prev_block_r <= '0; block_seen_r <= 1'b0; drop_r <= 1'b0;
      out_v_r <= 1'b0; pend_r <= 1'b0; mgo_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // start pulse for the merge stage on entry to an op
      mgo_r <= mstart ||
               (state_r == S_FOUT && out_tready && out_v_r && op_r != OW'(nops - 4'd1));
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_OP_COUNT:  op_count_r  <= cfg_data[3:0];
          CFG_OP_LIST:   op_list_r   <= cfg_data;
          CFG_BLK_FLUSH: blk_flush_r <= cfg_data[0];
          CFG_HAS_ID:    has_id_r    <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          pend_r <= in_tuser ||
                    (blk_flush_r && block_seen_r && prev_block_r != in_tdata[31:0]);
        end
        S_LOOK: if (!pend_r) begin
          if (blk_flush_r) begin prev_block_r <= blk_r; block_seen_r <= 1'b1; end
          if (!hit && !freeok) drop_r <= 1'b1;
          if (!hit && freeok) valid_r[free_s] <= 1'b1;
        end
        S_FSEL: if (!more_slot) begin
          drop_r <= 1'b0;
          if (cmd_r) block_seen_r <= 1'b0;
          pend_r <= 1'b0;
        end
        S_FOP: if (mrg_ok) out_v_r <= 1'b1;
        S_FOUT: if (out_tready && out_v_r && op_r == OW'(nops - 4'd1))
          valid_r[slot_r] <= 1'b0;
        default: ;
      endcase
    end
  end

  // result payload
  always_comb begin
    out_d_nxt = '0;
    out_d_nxt[31:0]  = key_r[slot_r];
    out_d_nxt[63:32] = fblk;
    out_d_nxt[67:64] = code;
    for (int c = 0; c < COLUMNS; c++) out_d_nxt[68 + 40*c +: 40] = mrg_res[c];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      cmd_r <= in_tuser;
      blk_r <= in_tdata[31:0];
      key_in_r <= has_id_r ? in_tdata[63:32] : 32'd0;
      for (int i = 0; i < 4; i++) val_r[i] <= in_tdata[64 + 16*i +: 16];
    end
    if (lctl.start) begin
      slot_r  <= hit ? hit_s : free_s;
      fresh_r <= !hit;
      if (!hit) begin
        key_r[free_s] <= key_in_r;
        cnt_r[free_s] <= COUNT_W'(1);
      end else cnt_r[hit_s] <= lctl.cnt;
    end
    if (state_r == S_UPD && &lane_done)
      for (int c = 0; c < COLUMNS; c++) acc_r[slot_r][c] <= lane_out[c];
    if (state_r == S_UPD && fresh_r)
      for (int c = 0; c < COLUMNS; c++) acc_r[slot_r][c] <= lane_out[c];
    if (mstart) begin slot_r <= nxt_s; op_r <= '0; end
    if (state_r == S_FOUT && out_tready && out_v_r) op_r <= op_r + 1'b1;
    if (mrg_ok) begin
      out_d_r <= out_d_nxt;
      out_drop_r <= drop_r;
      out_last_r <= op_r == OW'(nops - 4'd1) &&
                    ((valid_r & ~(ID_SLOTS'(1) << slot_r)) == '0);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_LOOK;
      S_LOOK: if (pend_r) state_nxt = S_FSEL;
              else if (hit || freeok) state_nxt = S_UPD;
              else state_nxt = S_IDLE;
      S_UPD:  if (fresh_r || &lane_done) state_nxt = S_IDLE;
      S_FSEL: if (more_slot) state_nxt = S_FOP;
              else state_nxt = cmd_r ? S_IDLE : S_LOOK;
      S_FOP:  if (mrg_ok) state_nxt = S_FOUT;
      S_FOUT: if (out_tready && out_v_r)
                state_nxt = (op_r == OW'(nops - 4'd1)) ? S_WAIT : S_FOP;
      S_WAIT: state_nxt = S_FSEL;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_drop_r;
  assign out_tlast  = out_last_r;
endmodule
